// File: rtl/core/toep_pkg.sv
// package for the tree object entry parser
// holds result kinds, error codes, phase and sequencer encodings and the hex digit map
// no dependencies
package toep_pkg;

	typedef enum logic [1:0] {
		K_MODE = 2'd0,
		K_PATH = 2'd1,
		K_HASH = 2'd2,
		K_ERR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		E_NONE    = 2'd0,
		E_MODELEN = 2'd1,
		E_NOTERM  = 2'd2,
		E_SHORT   = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		PH_MODE = 2'd0,
		PH_PATH = 2'd1,
		PH_HASH = 2'd2,
		PH_WAIT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MODE,
		ST_HEX
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_value;
		logic       entry_done;
		err_t       error_code;
		logic       run_last;
	} res_t;

	localparam logic [7:0] SPACE_CHAR    = 8'h20;
	localparam logic [7:0] NUL_CHAR      = 8'h00;
	localparam logic [7:0] MODE_PAD_CHAR = 8'h30;
	localparam int         MODE_DEPTH    = 6;
	localparam logic [2:0] MODE_LEN_SHORT = 3'd5;
	localparam logic [2:0] MODE_LEN_FULL  = 3'd6;
	localparam logic [2:0] MODE_LEN_SAT   = 3'd7;

	// lowercase hex digit for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h57 + {4'd0, nib};
		end
		return c;
	endfunction

endpackage

// File: rtl/core/toep_byte_if.sv
// input channel of the tree object entry parser: one object byte per transfer
// valid/ready handshake, no package dependency
interface toep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_object;

	modport source (output valid, output in_byte, output end_of_object, input ready);
	modport sink   (input valid, input in_byte, input end_of_object, output ready);
endinterface

// File: rtl/core/toep_result_if.sv
// result channel of the tree object entry parser: one result item per transfer
// valid/ready handshake, no package dependency
interface toep_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_value;
	logic       entry_done;
	logic [1:0] error_code;
	logic       run_last;

	modport source (output valid, output kind, output char_value, output entry_done,
		output error_code, output run_last, input ready);
	modport sink   (input valid, input kind, input char_value, input entry_done,
		input error_code, input run_last, output ready);
endinterface

// File: rtl/core/tree_object_entry_parser_core.sv
// the first result for a byte is registered and shows in the cycle after its transfer
// throughput: one byte per cycle for mode, path and waiting bytes unless the result
// channel stalls; a space closing a valid mode gives one result per mode character and
// a hash byte one per hex digit; the next byte waits until all of them are sent
// reset: arst_n clears the phase, counters, sequencer and output valid at once
// the mode character buffer has no reset and is written before it is read
module tree_object_entry_parser_core
	import toep_pkg::*;
#(
	parameter int HASH_BYTES = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	toep_byte_if.sink     byte_ch,
	toep_result_if.source result_ch
);

	localparam int HIDX_W = $clog2(HASH_BYTES);
	localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(HASH_BYTES - 1);

	// control state
	state_t            state_q, state_d;
	phase_t            phase_q, phase_d;
	logic [2:0]        len_q, len_d;
	logic [HIDX_W-1:0] hidx_q, hidx_d;

	// burst sequencer: read pointer into the mode buffer and its stop point
	logic [2:0] rd_idx_q, rd_idx_d;
	logic [2:0] last_idx_q, last_idx_d;
	// pending low nibble of a hash byte and whether it closes the entry
	logic [3:0] low_nib_q, low_nib_d;
	logic       hex_last_q, hex_last_d;

	// buffered mode characters
	logic [7:0] mode_q [MODE_DEPTH];
	logic       wr_mode;

	// output register
	res_t res_q, res_d;
	logic ov_q;
	logic load;
	logic out_free;
	logic acc;
	logic hash_last;

	assign out_free  = !ov_q || result_ch.ready;
	assign byte_ch.ready = (state_q == ST_IDLE) && out_free;
	assign acc       = byte_ch.valid && byte_ch.ready;
	assign hash_last = (hidx_q == HIDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_MODE;
			len_q      <= '0;
			hidx_q     <= '0;
			rd_idx_q   <= '0;
			last_idx_q <= '0;
			hex_last_q <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			len_q      <= len_d;
			hidx_q     <= hidx_d;
			rd_idx_q   <= rd_idx_d;
			last_idx_q <= last_idx_d;
			hex_last_q <= hex_last_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (result_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		low_nib_q <= low_nib_d;
		if (load) begin
			res_q <= res_d;
		end
		if (wr_mode) begin
			mode_q[len_q] <= byte_ch.in_byte;
		end
	end

	// sequencer: decides each result and loads it into the output register
	always_comb begin
		logic [7:0] b;
		logic       eob;
		b          = byte_ch.in_byte;
		eob        = byte_ch.end_of_object;
		state_d    = state_q;
		phase_d    = phase_q;
		len_d      = len_q;
		hidx_d     = hidx_q;
		rd_idx_d   = rd_idx_q;
		last_idx_d = last_idx_q;
		low_nib_d  = low_nib_q;
		hex_last_d = hex_last_q;
		wr_mode    = 1'b0;
		load       = 1'b0;
		res_d      = '{kind: K_ERR, char_value: 8'd0, entry_done: 1'b0,
			error_code: E_NONE, run_last: 1'b1};

		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (phase_q)
						PH_MODE: begin
							if (b != SPACE_CHAR) begin
								if (eob) begin
									load             = 1'b1;
									res_d.error_code = E_MODELEN;
									len_d            = '0;
									hidx_d           = '0;
								end else begin
									wr_mode = (len_q < 3'(MODE_DEPTH));
									if (len_q != MODE_LEN_SAT) begin
										len_d = len_q + 3'd1;
									end
								end
							end else if (len_q != MODE_LEN_SHORT && len_q != MODE_LEN_FULL) begin
								load             = 1'b1;
								res_d.error_code = E_MODELEN;
								len_d            = '0;
								hidx_d           = '0;
								phase_d          = eob ? PH_MODE : PH_WAIT;
							end else if (eob) begin
								load             = 1'b1;
								res_d.error_code = E_NOTERM;
								len_d            = '0;
								hidx_d           = '0;
							end else begin
								// first mode character now, rest from the buffer
								load           = 1'b1;
								res_d.kind     = K_MODE;
								res_d.run_last = 1'b0;
								if (len_q == MODE_LEN_SHORT) begin
									res_d.char_value = MODE_PAD_CHAR;
									rd_idx_d         = 3'd0;
									last_idx_d       = 3'd4;
								end else begin
									res_d.char_value = mode_q[0];
									rd_idx_d         = 3'd1;
									last_idx_d       = 3'd5;
								end
								phase_d = PH_PATH;
								state_d = ST_MODE;
							end
						end
						PH_PATH: begin
							if (eob) begin
								load             = 1'b1;
								res_d.error_code = (b == NUL_CHAR) ? E_SHORT : E_NOTERM;
								phase_d          = PH_MODE;
								len_d            = '0;
								hidx_d           = '0;
							end else if (b == NUL_CHAR) begin
								phase_d = PH_HASH;
								hidx_d  = '0;
							end else begin
								load             = 1'b1;
								res_d.kind       = K_PATH;
								res_d.char_value = b;
							end
						end
						PH_HASH: begin
							if (eob && !hash_last) begin
								load             = 1'b1;
								res_d.error_code = E_SHORT;
								phase_d          = PH_MODE;
								len_d            = '0;
								hidx_d           = '0;
							end else begin
								load             = 1'b1;
								res_d.kind       = K_HASH;
								res_d.char_value = hex_char(b[7:4]);
								res_d.run_last   = 1'b0;
								low_nib_d        = b[3:0];
								hex_last_d       = hash_last;
								state_d          = ST_HEX;
								if (hash_last) begin
									phase_d = PH_MODE;
									len_d   = '0;
									hidx_d  = '0;
								end else begin
									hidx_d = hidx_q + HIDX_W'(1);
								end
							end
						end
						PH_WAIT: begin
							// bytes dropped until the end of the object
							if (eob) begin
								phase_d = PH_MODE;
								len_d   = '0;
								hidx_d  = '0;
							end
						end
						default: begin
							phase_d = PH_MODE;
						end
					endcase
				end
			end
			ST_MODE: begin
				if (out_free) begin
					load             = 1'b1;
					res_d.kind       = K_MODE;
					res_d.char_value = mode_q[rd_idx_q];
					res_d.run_last   = (rd_idx_q == last_idx_q);
					rd_idx_d         = rd_idx_q + 3'd1;
					if (rd_idx_q == last_idx_q) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_HEX: begin
				if (out_free) begin
					load             = 1'b1;
					res_d.kind       = K_HASH;
					res_d.char_value = hex_char(low_nib_q);
					res_d.entry_done = hex_last_q;
					res_d.run_last   = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_ch.valid      = ov_q;
	assign result_ch.kind       = res_q.kind;
	assign result_ch.char_value = res_q.char_value;
	assign result_ch.entry_done = res_q.entry_done;
	assign result_ch.error_code = res_q.error_code;
	assign result_ch.run_last   = res_q.run_last;

endmodule

// File: rtl/core/toep_checker.sv
// port-level checks for the tree object entry parser
// depends on toep_pkg; bound to tree_object_entry_parser_core
module toep_checker
	import toep_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] char_value,
	input logic       entry_done,
	input logic [1:0] error_code,
	input logic       run_last
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// an error result is alone for its byte and carries no character
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_ERR |-> run_last && char_value == 8'd0)
		else $error("error result not standalone");

	// error code only on error results
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == K_ERR) == (error_code != E_NONE)))
		else $error("error code mismatch");

	// entry end only on the closing hex digit
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_done |-> kind == K_HASH && run_last)
		else $error("entry_done on wrong result");

endmodule

bind tree_object_entry_parser_core toep_checker u_toep_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.kind       (result_ch.kind),
	.char_value (result_ch.char_value),
	.entry_done (result_ch.entry_done),
	.error_code (result_ch.error_code),
	.run_last   (result_ch.run_last)
);

// File: tb/testbench.sv
// self-checking bench for tree_object_entry_parser_core: directed and random tree object bytes
// every accepted byte is run through a local parser model and the results are checked in order
// depends on toep_pkg, toep_byte_if, toep_result_if and the core itself
module testbench
	import toep_pkg::*;
();

	localparam int HASH_BYTES = 20;
	localparam int DIR_ROWS   = 32;

	// one byte for the byte channel; typed rows carry their single result written out by hand
	typedef struct {
		logic [7:0] data;
		logic       eoo;
		logic       typed;
		res_t       want;
	} stim_byte_t;

	localparam res_t NO_RESULT   = '0;
	localparam res_t MODELEN_ERR = '{K_ERR, 8'h00, 1'b0, E_MODELEN, 1'b1};
	localparam res_t NOTERM_ERR  = '{K_ERR, 8'h00, 1'b0, E_NOTERM, 1'b1};
	localparam res_t SHORT_ERR   = '{K_ERR, 8'h00, 1'b0, E_SHORT, 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	toep_byte_if   byte_ch ();
	toep_result_if result_ch ();

	tree_object_entry_parser_core #(
		.HASH_BYTES(HASH_BYTES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.result_ch(result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// directed bytes: error cases, both mode lengths, field extremes
	stim_byte_t directed_rows [DIR_ROWS] = '{
		'{8'h20, 1'b0, 1'b1, MODELEN_ERR},  // space with an empty mode, then waiting
		'{8'hFF, 1'b1, 1'b0, NO_RESULT},    // end flag leaves the waiting phase silently
		'{8'h00, 1'b1, 1'b1, MODELEN_ERR},  // object ends inside the mode
		'{8'h31, 1'b0, 1'b0, NO_RESULT},    // six character mode
		'{8'h30, 1'b0, 1'b0, NO_RESULT},
		'{8'h30, 1'b0, 1'b0, NO_RESULT},
		'{8'h36, 1'b0, 1'b0, NO_RESULT},
		'{8'h34, 1'b0, 1'b0, NO_RESULT},
		'{8'h34, 1'b0, 1'b0, NO_RESULT},
		'{8'h20, 1'b1, 1'b1, NOTERM_ERR},   // valid mode but object ends at the space
		'{8'h34, 1'b0, 1'b0, NO_RESULT},    // five character mode, gets the pad
		'{8'h30, 1'b0, 1'b0, NO_RESULT},
		'{8'h30, 1'b0, 1'b0, NO_RESULT},
		'{8'h30, 1'b0, 1'b0, NO_RESULT},
		'{8'h30, 1'b0, 1'b0, NO_RESULT},
		'{8'h20, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},    // path byte extremes
		'{8'h01, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},    // path terminator
		'{8'h00, 1'b0, 1'b0, NO_RESULT},    // hash byte extremes
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h5A, 1'b1, 1'b1, SHORT_ERR},    // truncated hash
		'{8'h80, 1'b0, 1'b0, NO_RESULT},    // eight character mode, count saturates
		'{8'h7F, 1'b0, 1'b0, NO_RESULT},
		'{8'h01, 1'b0, 1'b0, NO_RESULT},
		'{8'hFE, 1'b0, 1'b0, NO_RESULT},
		'{8'h21, 1'b0, 1'b0, NO_RESULT},
		'{8'h1F, 1'b0, 1'b0, NO_RESULT},
		'{8'hAA, 1'b0, 1'b0, NO_RESULT},
		'{8'h55, 1'b0, 1'b0, NO_RESULT},
		'{8'h20, 1'b0, 1'b1, MODELEN_ERR},  // overlong mode closed by a space
		'{8'h41, 1'b1, 1'b0, NO_RESULT}     // end of the broken object
	};

	stim_byte_t stim_q [$];
	res_t       expected_results [$];
	int         src_idle_pct = 33;
	int         sink_idle_pct = 46;
	int         random_queued = 0;
	int         mismatch_count = 0;

	// parser model state
	phase_t     parse_phase = PH_MODE;
	logic [7:0] mode_buf [MODE_DEPTH];
	logic [2:0] mode_count = 3'd0;
	logic [4:0] hash_pos = 5'd0;
	res_t       step_buf [6];
	int         step_n;

	function void add_result(kind_t k, logic [7:0] c, logic done, err_t code);
		res_t r;
		r.kind       = k;
		r.char_value = c;
		r.entry_done = done;
		r.error_code = code;
		r.run_last   = 1'b0;
		step_buf[step_n] = r;
		step_n++;
	endfunction

	function void start_entry();
		parse_phase = PH_MODE;
		mode_count  = 3'd0;
		hash_pos    = 5'd0;
	endfunction

	// error result; without the end flag the parser sits out the rest of the object
	function void raise_error(err_t code, logic eoo);
		add_result(K_ERR, 8'h00, 1'b0, code);
		start_entry();
		if (!eoo) begin
			parse_phase = PH_WAIT;
		end
	endfunction

	function logic [7:0] hex_digit(logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'h30 + {4'd0, nib};
		end
		return 8'h61 - 8'd10 + {4'd0, nib};
	endfunction

	// runs one accepted byte through the model and queues the results it should cause
	function void parse_tree_byte(stim_byte_t s);
		logic last_hash;
		res_t r;
		int   i;
		step_n = 0;
		case (parse_phase)
			PH_MODE: begin
				if (s.data != SPACE_CHAR) begin
					if (s.eoo) begin
						raise_error(E_MODELEN, 1'b1);
					end else begin
						if (mode_count < MODE_LEN_FULL) begin
							mode_buf[mode_count] = s.data;
						end
						if (mode_count < MODE_LEN_SAT) begin
							mode_count++;
						end
					end
				end else if (mode_count != MODE_LEN_SHORT && mode_count != MODE_LEN_FULL) begin
					raise_error(E_MODELEN, s.eoo);
				end else if (s.eoo) begin
					raise_error(E_NOTERM, 1'b1);
				end else begin
					if (mode_count == MODE_LEN_SHORT) begin
						add_result(K_MODE, MODE_PAD_CHAR, 1'b0, E_NONE);
					end
					for (i = 0; i < int'(mode_count); i++) begin
						add_result(K_MODE, mode_buf[i], 1'b0, E_NONE);
					end
					parse_phase = PH_PATH;
				end
			end
			PH_PATH: begin
				if (s.eoo) begin
					if (s.data == NUL_CHAR) begin
						raise_error(E_SHORT, 1'b1);
					end else begin
						raise_error(E_NOTERM, 1'b1);
					end
				end else if (s.data == NUL_CHAR) begin
					parse_phase = PH_HASH;
					hash_pos    = 5'd0;
				end else begin
					add_result(K_PATH, s.data, 1'b0, E_NONE);
				end
			end
			PH_HASH: begin
				last_hash = (int'(hash_pos) + 1 >= HASH_BYTES);
				if (s.eoo && !last_hash) begin
					raise_error(E_SHORT, 1'b1);
				end else begin
					add_result(K_HASH, hex_digit(s.data[7:4]), 1'b0, E_NONE);
					add_result(K_HASH, hex_digit(s.data[3:0]), last_hash, E_NONE);
					if (last_hash) begin
						start_entry();
					end else begin
						hash_pos = hash_pos + 5'd1;
					end
				end
			end
			default: begin
				if (s.eoo) begin
					start_entry();
				end
			end
		endcase
		if (s.typed) begin
			expected_results.push_back(s.want);
		end else begin
			for (i = 0; i < step_n; i++) begin
				r = step_buf[i];
				r.run_last = (i == step_n - 1);
				expected_results.push_back(r);
			end
		end
	endfunction

	// one random object: mostly well-formed entries, some cut short, some pure noise
	task automatic queue_object();
		stim_byte_t obj [$];
		stim_byte_t s;
		int         mode_len;
		int         cut;
		s.typed = 1'b0;
		s.want  = NO_RESULT;
		s.eoo   = 1'b0;
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(1, 12)) begin
				s.data = 8'($urandom_range(255));
				obj.push_back(s);
			end
		end else begin
			repeat ($urandom_range(1, 3)) begin
				// a few entries get a bad mode length
				mode_len = ($urandom_range(99) < 8) ? $urandom_range(0, 9) : $urandom_range(5, 6);
				repeat (mode_len) begin
					s.data = 8'($urandom_range(255));
					if (s.data == SPACE_CHAR) begin
						s.data = 8'h31;
					end
					obj.push_back(s);
				end
				s.data = SPACE_CHAR;
				obj.push_back(s);
				repeat ($urandom_range(0, 8)) begin
					s.data = 8'($urandom_range(1, 255));
					obj.push_back(s);
				end
				s.data = NUL_CHAR;
				obj.push_back(s);
				repeat (HASH_BYTES) begin
					s.data = 8'($urandom_range(255));
					obj.push_back(s);
				end
			end
			// truncated object: the end flag lands anywhere inside it
			if ($urandom_range(99) < 20) begin
				cut = $urandom_range(0, obj.size() - 1);
				while (obj.size() > cut + 1) begin
					void'(obj.pop_back());
				end
			end
		end
		s = obj.pop_back();
		s.eoo = 1'b1;
		obj.push_back(s);
		foreach (obj[i]) begin
			stim_q.push_back(obj[i]);
		end
		random_queued += obj.size();
	endtask

	function void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// byte sender: model update on each transfer, then the next byte or an idle cycle
	stim_byte_t cur_byte;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid         <= 1'b0;
			byte_ch.in_byte       <= 8'h00;
			byte_ch.end_of_object <= 1'b0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				parse_tree_byte(cur_byte);
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (stim_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_byte = stim_q.pop_front();
					byte_ch.valid         <= 1'b1;
					byte_ch.in_byte       <= cur_byte.data;
					byte_ch.end_of_object <= cur_byte.eoo;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: every transfer is matched against the oldest expected result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: kind %0d char %0d",
						result_ch.kind, result_ch.char_value);
					mismatch_count++;
				end else begin
					check_field("kind", 8'(expected_results[0].kind),
						8'(result_ch.kind));
					check_field("char_value", expected_results[0].char_value,
						result_ch.char_value);
					check_field("entry_done", 8'(expected_results[0].entry_done),
						8'(result_ch.entry_done));
					check_field("error_code", 8'(expected_results[0].error_code),
						8'(result_ch.error_code));
					check_field("run_last", 8'(expected_results[0].run_last),
						8'(result_ch.run_last));
					void'(expected_results.pop_front());
				end
			end
			result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed table first
		for (int i = 0; i < DIR_ROWS; i++) begin
			stim_q.push_back(directed_rows[i]);
		end

		// random objects in three idle settings: sender light, then receiver light, then none
		for (int p = 0; p < 3; p++) begin
			if (p == 1) begin
				src_idle_pct  = 46;
				sink_idle_pct = 33;
			end else if (p == 2) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			while (random_queued < 90 * (p + 1)) begin
				queue_object();
			end
			while (stim_q.size() != 0 || byte_ch.valid) begin
				@(negedge clk);
			end
		end

		// drain the result channel, then keep watching for stray results
		while (expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (10) @(negedge clk);

		if (mismatch_count == 0) begin
			$display("[tree_object_entry_parser_core] OK");
		end else begin
			$display("[tree_object_entry_parser_core] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("[tree_object_entry_parser_core] ERROR");
		$finish;
	end

endmodule
